// ----- rtl/core/mbtc_pkg.sv -----
// Shared types and codes for the Modbus TCP read-register client.
`default_nettype none
package mbtc_pkg;

  // Result word kinds
  localparam logic [1:0] KIND_REQ    = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_HEADER = 3'd1;
  localparam logic [2:0] ST_EXCEPTION  = 3'd2;
  localparam logic [2:0] ST_WRONG_FUNC = 3'd3;
  localparam logic [2:0] ST_COUNT      = 3'd4;

  // Function codes
  localparam logic [7:0] FN_HOLDING = 8'd3;
  localparam logic [7:0] FN_INPUT   = 8'd4;

  localparam logic [3:0] REQ_LAST_IDX = 4'd11;

  typedef struct packed {
    logic        req_type;
    logic        read_input_regs;
    logic [15:0] start_address;
    logic [15:0] reg_count;
    logic [7:0]  rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
    logic [2:0] status;
    logic [7:0] exc;
  } out_word_t;

  // Results of one accepted item: a request frame, or up to two result words
  typedef struct packed {
    logic        is_req;
    logic [1:0]  n_words;
    logic [15:0] tid;
    logic [7:0]  unit;
    logic [7:0]  fn;
    logic [15:0] addr;
    logic [15:0] cnt;
    out_word_t   w0;
    out_word_t   w1;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/core/mbtc_parser.sv -----
// Request framing state and response header/PDU parser.
`default_nettype none
module mbtc_parser import mbtc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_data,
  input  wire logic       accept,
  input  in_word_t        in_w,
  output res_t            res
);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_PDU    = 2'd2;
  localparam logic [1:0] PH_DROP   = 2'd3;

  logic [7:0]  unit_r;
  logic [15:0] tid_r, tid_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [2:0]  hidx_r, hidx_nxt;
  logic [47:0] hshift_r, hshift_nxt;
  logic        fn_in_r, fn_in_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] size_r, size_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [7:0]  exc_r, exc_nxt;

  logic [7:0]  b;
  logic [7:0]  exp_fn;
  logic [15:0] hlen;
  logic [8:0]  bcnt;

  assign b      = in_w.rx_byte;
  assign exp_fn = fn_in_r ? FN_INPUT : FN_HOLDING;
  assign hlen   = hshift_r[15:0];
  assign bcnt   = {1'b0, b} + 9'd2;

  always_comb begin
    tid_nxt    = tid_r;
    phase_nxt  = phase_r;
    hidx_nxt   = hidx_r;
    hshift_nxt = hshift_r;
    fn_in_nxt  = fn_in_r;
    rem_nxt    = rem_r;
    size_nxt   = size_r;
    pos_nxt    = pos_r;
    err_nxt    = err_r;
    exc_nxt    = exc_r;

    res         = '0;
    res.tid     = tid_r + 16'd1;
    res.unit    = unit_r;
    res.fn      = in_w.read_input_regs ? FN_INPUT : FN_HOLDING;
    res.addr    = in_w.start_address;
    res.cnt     = in_w.reg_count;

    if (!in_w.req_type) begin
      res.is_req = 1'b1;
      tid_nxt    = tid_r + 16'd1;
      fn_in_nxt  = in_w.read_input_regs;
      phase_nxt  = PH_HEADER;
      hidx_nxt   = '0;
      hshift_nxt = '0;
      rem_nxt    = '0;
      size_nxt   = '0;
      pos_nxt    = '0;
      err_nxt    = ST_OK;
      exc_nxt    = '0;
    end else begin
      unique case (phase_r)
        PH_HEADER: begin
          if (hidx_r != 3'd6) begin
            hshift_nxt = {hshift_r[39:0], b};
            hidx_nxt   = hidx_r + 3'd1;
          end else begin
            hidx_nxt = '0;
            if (hshift_r[47:32] != tid_r || hshift_r[31:16] != 16'd0 ||
                b != unit_r || hlen < 16'd2) begin
              phase_nxt        = PH_DROP;
              res.n_words      = 2'd1;
              res.w0.kind      = KIND_STATUS;
              res.w0.last      = 1'b1;
              res.w0.status    = ST_BAD_HEADER;
            end else begin
              rem_nxt   = hlen - 16'd1;
              size_nxt  = hlen - 16'd1;
              pos_nxt   = '0;
              err_nxt   = ST_OK;
              exc_nxt   = '0;
              phase_nxt = PH_PDU;
            end
          end
        end
        PH_PDU: begin
          if (pos_r == 2'd0) begin
            if (b[7]) begin
              err_nxt = ST_EXCEPTION;
            end else if (b != exp_fn || size_r < 16'd2) begin
              err_nxt = ST_WRONG_FUNC;
            end
          end else if (pos_r == 2'd1) begin
            if (err_r == ST_EXCEPTION) begin
              exc_nxt = b;
            end else if (err_r == ST_OK && {7'd0, bcnt} != size_r) begin
              err_nxt = ST_COUNT;
            end
          end else if (err_r == ST_OK) begin
            res.n_words  = 2'd1;
            res.w0.kind  = KIND_DATA;
            res.w0.data  = b;
          end
          // saturate position: only first, second and later matter
          if (pos_r != 2'd2) begin
            pos_nxt = pos_r + 2'd1;
          end
          rem_nxt = rem_r - 16'd1;
          if (rem_r == 16'd1) begin
            phase_nxt = PH_IDLE;
            if (res.n_words == 2'd1) begin
              res.n_words = 2'd2;
              res.w1.kind   = KIND_STATUS;
              res.w1.last   = 1'b1;
              res.w1.status = err_nxt;
              res.w1.exc    = (err_nxt == ST_EXCEPTION) ? exc_nxt : 8'd0;
            end else begin
              res.n_words = 2'd1;
              res.w0.kind   = KIND_STATUS;
              res.w0.last   = 1'b1;
              res.w0.status = err_nxt;
              res.w0.exc    = (err_nxt == ST_EXCEPTION) ? exc_nxt : 8'd0;
            end
          end
        end
        default: begin
          // idle or dropping: ignore the byte
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_r   <= 8'd1;
      tid_r    <= '0;
      phase_r  <= PH_IDLE;
      hidx_r   <= '0;
      hshift_r <= '0;
      fn_in_r  <= 1'b0;
      rem_r    <= '0;
      size_r   <= '0;
      pos_r    <= '0;
      err_r    <= ST_OK;
      exc_r    <= '0;
    end else begin
      if (cfg_we) begin
        unit_r <= cfg_data;
      end
      if (accept) begin
        tid_r    <= tid_nxt;
        phase_r  <= phase_nxt;
        hidx_r   <= hidx_nxt;
        hshift_r <= hshift_nxt;
        fn_in_r  <= fn_in_nxt;
        rem_r    <= rem_nxt;
        size_r   <= size_nxt;
        pos_r    <= pos_nxt;
        err_r    <= err_nxt;
        exc_r    <= exc_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/mbtc_outbuf.sv -----
// Result register: holds one item's result words and plays them out one per cycle while out_stall is low.
`default_nettype none
module mbtc_outbuf import mbtc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic load,
  input  res_t      res,
  output logic      can_load,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_word_t out_w
);

  logic        busy_r;
  logic        is_req_r;
  logic [3:0]  idx_r;
  logic [3:0]  last_idx_r;
  logic [15:0] tid_r;
  logic [7:0]  unit_r;
  logic [7:0]  fn_r;
  logic [15:0] addr_r;
  logic [15:0] cnt_r;
  out_word_t   w0_r, w1_r;

  logic take, done;
  logic [7:0] req_b;

  assign out_valid = busy_r;
  assign take      = busy_r && !out_stall;
  assign done      = take && (idx_r == last_idx_r);
  assign can_load  = !busy_r || done;

  always_comb begin
    unique case (idx_r)
      4'd0:    req_b = tid_r[15:8];
      4'd1:    req_b = tid_r[7:0];
      4'd5:    req_b = 8'h06;
      4'd6:    req_b = unit_r;
      4'd7:    req_b = fn_r;
      4'd8:    req_b = addr_r[15:8];
      4'd9:    req_b = addr_r[7:0];
      4'd10:   req_b = cnt_r[15:8];
      4'd11:   req_b = cnt_r[7:0];
      default: req_b = 8'h00;
    endcase
  end

  always_comb begin
    if (is_req_r) begin
      out_w        = '0;
      out_w.kind   = KIND_REQ;
      out_w.data   = req_b;
      out_w.last   = (idx_r == REQ_LAST_IDX);
    end else if (idx_r == 4'd0) begin
      out_w = w0_r;
    end else begin
      out_w = w1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      if (load && (res.is_req || res.n_words != 2'd0)) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (done) begin
        busy_r <= 1'b0;
      end else if (take) begin
        idx_r <= idx_r + 4'd1;
      end
    end
  end

  // payload: capture on load
  always_ff @(posedge clk) begin
    if (load) begin
      is_req_r   <= res.is_req;
      last_idx_r <= res.is_req ? REQ_LAST_IDX : {2'b00, res.n_words - 2'd1};
      tid_r      <= res.tid;
      unit_r     <= res.unit;
      fn_r       <= res.fn;
      addr_r     <= res.addr;
      cnt_r      <= res.cnt;
      w0_r       <= res.w0;
      w1_r       <= res.w1;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/modbus_tcp_read_register_client_top.sv -----
// Modbus TCP read-register client: request framer and response deframer.
// The first result word is presented in the cycle after the item is accepted.
// One response byte per cycle while out_stall is low; a last PDU byte that gives a payload
// word and the status word stalls the input while its first word is played out, and a
// request occupies the result register until all 12 frame bytes have been played out.
// Reset (rst_n low, synchronous): parser idle, transaction counter zero,
// unit address 1, result register empty.
`default_nettype none
module modbus_tcp_read_register_client_top import mbtc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_req_type,
  input  wire logic        in_read_input_regs,
  input  wire logic [15:0] in_start_address,
  input  wire logic [15:0] in_reg_count,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_byte,
  output logic             out_last,
  output logic [2:0]       out_status_code,
  output logic [7:0]       out_exception_code,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);

  in_word_t  in_w;
  res_t      res;
  out_word_t out_w;
  logic      can_load;
  logic      accept;

  assign in_w.req_type        = in_req_type;
  assign in_w.read_input_regs = in_read_input_regs;
  assign in_w.start_address   = in_start_address;
  assign in_w.reg_count       = in_reg_count;
  assign in_w.rx_byte         = in_rx_byte;

  assign cfg_ready = 1'b1;
  assign in_stall  = !can_load;
  assign accept    = in_valid && can_load;

  mbtc_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid),
    .cfg_data (cfg_data),
    .accept   (accept),
    .in_w     (in_w),
    .res      (res)
  );

  mbtc_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_w     (out_w)
  );

  assign out_kind           = out_w.kind;
  assign out_byte           = out_w.data;
  assign out_last           = out_w.last;
  assign out_status_code    = out_w.status;
  assign out_exception_code = out_w.exc;

endmodule
`default_nettype wire

// ----- sim/modbus_tcp_read_register_client_top_test.sv -----
// Self-checking testbench for the Modbus TCP read-register client top level.
`timescale 1ns / 1ps
module modbus_tcp_read_register_client_top_test;
  import mbtc_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam logic [7:0] MBAP_REQ_LEN = 8'h06;
  localparam logic [7:0] FN_EXC_FLAG = 8'h80;

  typedef enum logic [1:0] {P_IDLE, P_HEADER, P_PDU, P_DROP} parse_e;
  typedef enum logic [2:0] {HF_NONE, HF_TID, HF_PROTO, HF_UNIT, HF_LEN} fault_e;

  // One request and the response that answers it
  typedef struct {
    bit          rif;
    logic [15:0] addr, cnt;
    fault_e      fault;
    logic [15:0] len;
    logic [7:0]  fn_byte, second;
    int          cut, tail;
    bit          swap;
    logic [7:0]  new_unit;
    bit          typed;
    logic [2:0]  t_status;
    logic [7:0]  t_exc;
  } exchange_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid, in_stall;
  logic        in_req_type, in_read_input_regs;
  logic [15:0] in_start_address, in_reg_count;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte;
  logic        out_last;
  logic [2:0]  out_status_code;
  logic [7:0]  out_exception_code;
  logic        cfg_valid, cfg_ready;
  logic [7:0]  cfg_data;

  // Client state as the block should hold it
  logic [7:0]  unit_reg = 8'd1;
  logic [15:0] tid_ctr = 16'd0;
  parse_e      phase = P_IDLE;
  logic [2:0]  hdr_idx = 3'd0;
  logic [47:0] hdr_bits = 48'd0;
  logic [7:0]  want_fn = 8'd0;
  logic [15:0] pdu_left = 16'd0;
  logic [15:0] pdu_pos = 16'd0;
  logic [2:0]  pend = ST_OK;
  logic [7:0]  exc_saved = 8'd0;

  out_word_t   due_words[$];
  exchange_t   plan[$];
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          mismatches = 0;
  int          items_sent = 0;
  int          words_checked = 0;
  int          statuses_seen = 0;
  int          cycles = 0;

  modbus_tcp_read_register_client_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_read_input_regs(in_read_input_regs),
    .in_start_address(in_start_address), .in_reg_count(in_reg_count),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_kind(out_kind), .out_byte(out_byte), .out_last(out_last),
    .out_status_code(out_status_code), .out_exception_code(out_exception_code),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words still due", cycles, due_words.size());
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall = (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  task automatic report(input string what);
    $display("%0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic void push_word(input logic [1:0] kind, input logic [7:0] data,
                                    input logic last, input logic [2:0] st,
                                    input logic [7:0] exc);
    due_words.push_back(out_word_t'{kind, data, last, st, exc});
  endfunction

  // Advance the client state by one accepted word and queue what it must emit
  function automatic void client_step(input in_word_t w);
    logic [7:0]  fn;
    logic [7:0]  b;
    logic [16:0] pdu_size;
    logic [7:0]  frame [12];
    if (!w.req_type) begin
      fn = w.read_input_regs ? FN_INPUT : FN_HOLDING;
      tid_ctr = tid_ctr + 16'd1;
      frame = '{tid_ctr[15:8], tid_ctr[7:0], 8'h00, 8'h00, 8'h00, MBAP_REQ_LEN, unit_reg,
                fn, w.start_address[15:8], w.start_address[7:0],
                w.reg_count[15:8], w.reg_count[7:0]};
      for (int i = 0; i < 12; i++)
        push_word(KIND_REQ, frame[i], i == int'(REQ_LAST_IDX), ST_OK, 8'h00);
      want_fn = fn;
      phase = P_HEADER;
      hdr_idx = 3'd0;
      hdr_bits = 48'd0;
      pdu_left = 16'd0;
      pdu_pos = 16'd0;
      pend = ST_OK;
      exc_saved = 8'd0;
    end else begin
      b = w.rx_byte;
      case (phase)
        P_HEADER: begin
          if (hdr_idx < 3'd6) begin
            hdr_bits = {hdr_bits[39:0], b};
            hdr_idx = hdr_idx + 3'd1;
          end else begin
            hdr_idx = 3'd0;
            if (hdr_bits[47:32] != tid_ctr || hdr_bits[31:16] != 16'h0000 ||
                b != unit_reg || hdr_bits[15:0] < 16'd2) begin
              phase = P_DROP;
              push_word(KIND_STATUS, 8'h00, 1'b1, ST_BAD_HEADER, 8'h00);
            end else begin
              pdu_left = hdr_bits[15:0] - 16'd1;
              pdu_pos = 16'd0;
              pend = ST_OK;
              exc_saved = 8'd0;
              phase = P_PDU;
            end
          end
        end
        P_PDU: begin
          pdu_size = {1'b0, pdu_pos} + {1'b0, pdu_left};
          if (pdu_pos == 16'd0) begin
            if (b[7])
              pend = ST_EXCEPTION;
            else if (b != want_fn || pdu_size < 17'd2)
              pend = ST_WRONG_FUNC;
          end else if (pdu_pos == 16'd1) begin
            if (pend == ST_EXCEPTION)
              exc_saved = b;
            else if (pend == ST_OK && {9'd0, b} + 17'd2 != pdu_size)
              pend = ST_COUNT;
          end else if (pend == ST_OK) begin
            push_word(KIND_DATA, b, 1'b0, ST_OK, 8'h00);
          end
          pdu_pos = pdu_pos + 16'd1;
          pdu_left = pdu_left - 16'd1;
          if (pdu_left == 16'd0) begin
            push_word(KIND_STATUS, 8'h00, 1'b1, pend,
                      pend == ST_EXCEPTION ? exc_saved : 8'h00);
            phase = P_IDLE;
          end
        end
        default: ;
      endcase
    end
  endfunction

  always @(posedge clk) begin
    out_word_t got;
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = out_word_t'{out_kind, out_byte, out_last, out_status_code, out_exception_code};
      if (due_words.size() == 0) begin
        report($sformatf("unexpected word kind %0d byte %02h last %0d status %0d exc %02h",
                         got.kind, got.data, got.last, got.status, got.exc));
      end else begin
        want = due_words.pop_front();
        words_checked++;
        if (want.kind == KIND_STATUS)
          statuses_seen++;
        if (got.kind !== want.kind || got.data !== want.data || got.last !== want.last ||
            got.status !== want.status || got.exc !== want.exc)
          report($sformatf("word %0d: got kind %0d byte %02h last %0d status %0d exc %02h, want %0d %02h %0d %0d %02h",
                           words_checked, got.kind, got.data, got.last, got.status, got.exc,
                           want.kind, want.data, want.last, want.status, want.exc));
      end
    end
  end

  // Present one word, hold it through stalls, advance the client on acceptance
  task automatic send_item(input in_word_t w);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_req_type = w.req_type;
    in_read_input_regs = w.read_input_regs;
    in_start_address = w.start_address;
    in_reg_count = w.reg_count;
    in_rx_byte = w.rx_byte;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    client_step(w);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_word_t w;
    w.req_type = 1'b1;
    w.read_input_regs = 1'($urandom_range(1));
    w.start_address = 16'($urandom);
    w.reg_count = 16'($urandom);
    w.rx_byte = b;
    send_item(w);
  endtask

  // Write the unit id only once nothing is in flight
  task automatic set_unit(input logic [7:0] v);
    in_valid = 1'b0;
    while (due_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    unit_reg = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic exchange_t mk(input bit rif, input logic [15:0] addr, cnt,
                                   input fault_e fault, input logic [15:0] len,
                                   input logic [7:0] fn_byte, second, input int cut, tail,
                                   input bit swap, input logic [7:0] new_unit,
                                   input bit typed, input logic [2:0] t_status,
                                   input logic [7:0] t_exc);
    exchange_t x;
    x.rif = rif;
    x.addr = addr;
    x.cnt = cnt;
    x.fault = fault;
    x.len = len;
    x.fn_byte = fn_byte;
    x.second = second;
    x.cut = cut;
    x.tail = tail;
    x.swap = swap;
    x.new_unit = new_unit;
    x.typed = typed;
    x.t_status = t_status;
    x.t_exc = t_exc;
    return x;
  endfunction

  // Random replies: some well-formed, the rest exceptions, broken or cut short
  function automatic exchange_t rand_exchange();
    bit         rif;
    logic [7:0] fn, second;
    logic [15:0] len;
    fault_e     fault;
    int         n, pick, total, cut, tail;
    bit         swap;
    rif = 1'($urandom_range(1));
    fn = rif ? FN_INPUT : FN_HOLDING;
    n = ($urandom_range(19) == 0) ? 253 : $urandom_range(8);
    len = 16'(n + 3);
    second = 8'(n);
    fault = HF_NONE;
    pick = $urandom_range(99);
    if (pick < 8) begin
      fault = HF_TID;
    end else if (pick < 14) begin
      fault = HF_PROTO;
    end else if (pick < 20) begin
      fault = HF_UNIT;
    end else if (pick < 26) begin
      fault = HF_LEN;
      len = 16'($urandom_range(1));
    end else if (pick < 40) begin
      fn = FN_EXC_FLAG | 8'($urandom_range(127));
      len = 16'($urandom_range(2, 5));
      second = 8'($urandom);
    end else if (pick < 50) begin
      fn = 8'($urandom_range(127));
      if (fn == (rif ? FN_INPUT : FN_HOLDING))
        fn = fn ^ 8'h01;
    end else if (pick < 58) begin
      len = 16'd2;
    end else if (pick < 68) begin
      second = 8'(n + 1 + $urandom_range(250));
    end
    total = (fault == HF_NONE) ? 6 + int'(len) : 7;
    cut = ($urandom_range(9) == 0) ? $urandom_range(total - 1) : -1;
    tail = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
    swap = ($urandom_range(11) == 0);
    return mk(rif, 16'($urandom), 16'($urandom), fault, len, fn, second, cut, tail,
              swap, 8'($urandom), 1'b0, ST_OK, 8'h00);
  endfunction

  task automatic run_exchange(input exchange_t x);
    in_word_t    w;
    logic [15:0] tid_sent, proto;
    logic [7:0]  hdr [6];
    logic [7:0]  b;
    int          total;
    w.req_type = 1'b0;
    w.read_input_regs = x.rif;
    w.start_address = x.addr;
    w.reg_count = x.cnt;
    w.rx_byte = 8'($urandom);
    send_item(w);
    tid_sent = tid_ctr;
    if (x.fault == HF_TID)
      tid_sent = tid_sent ^ (16'h0001 << $urandom_range(15));
    proto = (x.fault == HF_PROTO) ? 16'($urandom_range(1, 65535)) : 16'h0000;
    hdr = '{tid_sent[15:8], tid_sent[7:0], proto[15:8], proto[7:0], x.len[15:8], x.len[7:0]};
    total = (x.fault == HF_NONE) ? 6 + int'(x.len) : 7;
    for (int k = 0; k < total; k++) begin
      if (x.cut >= 0 && k >= x.cut)
        break;
      if (k == 6 && x.swap)
        set_unit(x.new_unit);
      if (k < 6)
        b = hdr[k];
      else if (k == 6)
        b = (x.fault == HF_UNIT) ? unit_reg ^ 8'($urandom_range(1, 255)) : unit_reg;
      else if (k == 7)
        b = x.fn_byte;
      else if (k == 8)
        b = x.second;
      else
        b = 8'($urandom);
      send_byte(b);
    end
    // Hold the closing status to the hand-written value
    if (x.typed && due_words.size() != 0)
      due_words[$] = out_word_t'{KIND_STATUS, 8'h00, 1'b1, x.t_status, x.t_exc};
    repeat (x.tail) send_byte(8'($urandom));
  endtask

  initial begin
    int start;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = 1'b0;
    in_read_input_regs = 1'b0;
    in_start_address = 16'h0000;
    in_reg_count = 16'h0000;
    in_rx_byte = 8'h00;
    cfg_valid = 1'b0;
    cfg_data = 8'h00;
    //           rif addr      cnt       fault     len      fn          2nd    cut tail
    //           swap unit typed status exc
    plan.push_back(mk(1, 16'hFFFF, 16'hFFFF, HF_NONE, 16'd5, FN_INPUT, 8'd2, -1, 0,
                      0, 8'h00, 1, ST_OK, 8'h00));
    plan.push_back(mk(0, 16'h0000, 16'h0000, HF_TID, 16'd5, FN_HOLDING, 8'd2, -1, 2,
                      0, 8'h00, 1, ST_BAD_HEADER, 8'h00));
    plan.push_back(mk(1, 16'h1234, 16'h0001, HF_PROTO, 16'd5, FN_INPUT, 8'd2, -1, 0,
                      0, 8'h00, 1, ST_BAD_HEADER, 8'h00));
    plan.push_back(mk(0, 16'h8000, 16'h007D, HF_UNIT, 16'd5, FN_HOLDING, 8'd2, -1, 1,
                      0, 8'h00, 1, ST_BAD_HEADER, 8'h00));
    plan.push_back(mk(1, 16'h00FF, 16'hFF00, HF_LEN, 16'd1, FN_INPUT, 8'd0, -1, 0,
                      0, 8'h00, 1, ST_BAD_HEADER, 8'h00));
    plan.push_back(mk(0, 16'h0001, 16'h0002, HF_NONE, 16'd3, 8'h83, 8'h0B, -1, 2,
                      0, 8'h00, 1, ST_EXCEPTION, 8'h0B));
    plan.push_back(mk(1, 16'h0010, 16'h0003, HF_NONE, 16'd2, 8'h84, 8'h00, -1, 0,
                      0, 8'h00, 1, ST_EXCEPTION, 8'h00));
    plan.push_back(mk(1, 16'h0020, 16'h0001, HF_NONE, 16'd4, FN_HOLDING, 8'd1, -1, 0,
                      0, 8'h00, 1, ST_WRONG_FUNC, 8'h00));
    plan.push_back(mk(0, 16'h0030, 16'h0001, HF_NONE, 16'd2, FN_HOLDING, 8'd0, -1, 0,
                      0, 8'h00, 1, ST_WRONG_FUNC, 8'h00));
    plan.push_back(mk(0, 16'h0040, 16'h0001, HF_NONE, 16'd5, FN_HOLDING, 8'd7, -1, 0,
                      0, 8'h00, 1, ST_COUNT, 8'h00));
    // Longest length field, cut short: the next request abandons it
    plan.push_back(mk(1, 16'h7FFF, 16'h8000, HF_NONE, 16'hFFFF, FN_INPUT, 8'hFF, 9, 0,
                      0, 8'h00, 0, ST_OK, 8'h00));
    plan.push_back(mk(0, 16'hAAAA, 16'h5555, HF_NONE, 16'd3, FN_HOLDING, 8'd0, -1, 0,
                      1, 8'hFF, 1, ST_OK, 8'h00));
    plan.push_back(mk(1, 16'h5555, 16'hAAAA, HF_NONE, 16'd6, FN_INPUT, 8'd3, -1, 1,
                      1, 8'h00, 1, ST_OK, 8'h00));
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    // Bytes before any request are ignored
    repeat (2) send_byte(8'($urandom));
    foreach (plan[i]) run_exchange(plan[i]);
    for (int p = 0; p < 4; p++) begin
      gap_pct = (p == 1) ? 55 : (p == 3) ? 14 : 0;
      stall_pct = (p == 2) ? 55 : (p == 3) ? 14 : 0;
      set_unit(p == 0 ? 8'h00 : p == 1 ? 8'hFF : 8'($urandom));
      start = items_sent;
      while (items_sent - start < 30) run_exchange(rand_exchange());
    end
    in_valid = 1'b0;
    while (due_words.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("Sent %0d words (requests and reply bytes) over four idle/stall mixes,",
             items_sent);
    $display("checked %0d result words including %0d status words", words_checked,
             statuses_seen);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/mbtc_pkg.sv
rtl/core/mbtc_parser.sv
rtl/core/mbtc_outbuf.sv
rtl/core/modbus_tcp_read_register_client_top.sv
sim/modbus_tcp_read_register_client_top_test.sv
